// ----- hdl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the calculator RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calculator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calculator assertion failed");

`endif

// ----- hdl/iic_pkg.sv -----
// -----------------------------------------------------------------------------
// Calculator package
// Widths, key and status codes, and the request and response types of the
// shared multiply and divide unit.
// -----------------------------------------------------------------------------
package iic_pkg;

  localparam int DATA_W       = 32;
  localparam int MAG_W        = DATA_W - 1;
  localparam int MODE_W       = 3;
  localparam int DIGIT_W      = 4;
  localparam int STAT_W       = 2;
  localparam int ITER_W       = 5;
  localparam int LIT_DIGITS_W = 4;
  localparam int MAX_KEYS_DEF = 20;

  localparam logic [MODE_W-1:0] MODE_DIGIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EQ    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLR   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_SYNTAX = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER   = 2'd2;

  localparam logic [1:0] MD_NONE  = 2'd0;
  localparam logic [1:0] MD_TIMES = 2'd1;
  localparam logic [1:0] MD_DIV   = 2'd2;

  localparam logic [DATA_W-1:0]  LIMIT_POS = 32'h7FFF_FFFF;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_rsp_t;

endpackage

// ----- hdl/iic_key_if.sv -----
// -----------------------------------------------------------------------------
// Key channel
// Valid and ready handshake carrying one calculator key per beat.
// -----------------------------------------------------------------------------
interface iic_key_if;
  import iic_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DIGIT_W-1:0] digit;

  modport source (output valid, output mode, output digit, input ready);
  modport sink   (input valid, input mode, input digit, output ready);
endinterface

// ----- hdl/iic_res_if.sv -----
// -----------------------------------------------------------------------------
// Result channel
// Valid and ready handshake carrying one evaluated result per beat.
// -----------------------------------------------------------------------------
interface iic_res_if;
  import iic_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- hdl/infix_integer_calculator.sv -----
// Key flow: a clear key is handled in idle, a digit passes through decode, and an operator
// after a plain literal passes through decode and fold, with add or subtract going on to sum.
// Folding a pending multiply or divide starts the 31-step shared unit in fold and waits on
// it in wait; equals decides its beat in decode, fold, wait or sum, the wait only when it
// folds a pending multiply or divide.
// Throughput: one key at a time; the next key is taken once the block is back in idle and no result beat waits.
// Reset (synchronous, active low) clears the expression as the clear key does.
// -----------------------------------------------------------------------------
// Infix integer calculator
// Evaluates keyed integer expressions with multiply and divide ahead of add
// and subtract, and returns the value and a status on equals.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module infix_integer_calculator #(
  parameter int MAX_KEYS = iic_pkg::MAX_KEYS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  iic_key_if.sink   in_ch,
  iic_res_if.source out_ch
);
  import iic_pkg::*;

  localparam int KEY_W = $clog2(MAX_KEYS + 1);
  localparam int NV_W  = MAG_W + 4;
  localparam logic [NV_W-1:0] LIT_HI = NV_W'(LIMIT_POS);
  localparam logic signed [DATA_W:0] SUM_HI = {1'b0, LIMIT_POS};
  localparam logic signed [DATA_W:0] SUM_LO = -SUM_HI;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_FOLD   = 5'b00100,
    S_WAIT   = 5'b01000,
    S_SUM    = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [DIGIT_W-1:0]       digit_r, digit_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  logic signed [DATA_W-1:0] prod_r, prod_nxt;
  logic signed [DATA_W-1:0] term_r, term_nxt;
  logic [MAG_W-1:0]         lit_r, lit_nxt;
  logic [LIT_DIGITS_W-1:0]  lit_digits_r, lit_digits_nxt;
  logic                     sign_r, sign_nxt;
  logic [1:0]               muldiv_r, muldiv_nxt;
  logic [KEY_W-1:0]         key_count_r, key_count_nxt;
  logic                     last_op_r, last_op_nxt;
  logic [STAT_W-1:0]        err_r, err_nxt;
  logic                     after_eq_r, after_eq_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;

  logic                     clear_req, set_after_eq, emit;
  logic [STAT_W-1:0]        emit_status;
  logic signed [DATA_W-1:0] emit_value;
  logic                     term_ok, term_fail;
  logic [STAT_W-1:0]        term_fail_st;
  logic signed [DATA_W-1:0] term_val;
  logic [NV_W-1:0]          lit_ext, nv;
  logic signed [DATA_W:0]   sum_ext;
  logic                     sum_ovf;
  logic signed [DATA_W-1:0] neg_prod, mag_ext;
  logic [MAG_W-1:0]         prod_mag, md_res;
  md_req_t                  md_req;
  md_rsp_t                  md_rsp;

  assign lit_ext  = {{(NV_W-MAG_W){1'b0}}, lit_r};
  assign nv       = (lit_ext << 3) + (lit_ext << 1) + NV_W'(digit_r);
  assign sum_ext  = sign_r ? ({sum_r[DATA_W-1], sum_r} - {term_r[DATA_W-1], term_r})
                           : ({sum_r[DATA_W-1], sum_r} + {term_r[DATA_W-1], term_r});
  assign sum_ovf  = (sum_ext > SUM_HI) || (sum_ext < SUM_LO);
  assign neg_prod = -prod_r;
  assign prod_mag = prod_r[DATA_W-1] ? neg_prod[MAG_W-1:0] : prod_r[MAG_W-1:0];
  assign mag_ext  = {1'b0, md_res};

  iic_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .opa   (prod_mag),
    .opb   (lit_r),
    .rsp   (md_rsp),
    .res   (md_res)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    digit_nxt      = digit_r;
    sum_nxt        = sum_r;
    prod_nxt       = prod_r;
    term_nxt       = term_r;
    lit_nxt        = lit_r;
    lit_digits_nxt = lit_digits_r;
    sign_nxt       = sign_r;
    muldiv_nxt     = muldiv_r;
    key_count_nxt  = key_count_r;
    last_op_nxt    = last_op_r;
    err_nxt        = err_r;
    after_eq_nxt   = after_eq_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    clear_req      = 1'b0;
    set_after_eq   = 1'b0;
    emit           = 1'b0;
    emit_status    = ST_OK;
    emit_value     = '0;
    term_ok        = 1'b0;
    term_fail      = 1'b0;
    term_fail_st   = ST_OK;
    term_val       = term_r;
    md_req         = '0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          mode_nxt  = in_ch.mode;
          digit_nxt = in_ch.digit;
          if (in_ch.mode == MODE_CLR) begin
            clear_req = 1'b1;
          end else if (in_ch.mode == MODE_EQ) begin
            state_nxt = S_DECODE;
          end else if (in_ch.mode == MODE_DIGIT && in_ch.digit > DIGIT_MAX) begin
            state_nxt = S_IDLE;
          end else if (in_ch.mode <= MODE_DIV) begin
            clear_req = after_eq_r;
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (mode_r == MODE_EQ) begin
          if (err_r != ST_OK || key_count_r == '0) begin
            emit        = 1'b1;
            emit_status = err_r;
          end else if (last_op_r) begin
            emit        = 1'b1;
            emit_status = ST_SYNTAX;
          end else begin
            state_nxt = S_FOLD;
          end
        end else if (key_count_r < KEY_W'(MAX_KEYS)) begin
          key_count_nxt = key_count_r + 1'b1;
          if (err_r == ST_OK) begin
            if (mode_r == MODE_DIGIT) begin
              if (nv > LIT_HI) begin
                err_nxt = ST_OVER;
              end else begin
                lit_nxt     = nv[MAG_W-1:0];
                last_op_nxt = 1'b0;
                if (lit_digits_r != '1) begin
                  lit_digits_nxt = lit_digits_r + 1'b1;
                end
              end
            end else if (key_count_r == '0 || last_op_r) begin
              err_nxt = ST_SYNTAX;
            end else begin
              last_op_nxt = 1'b1;
              state_nxt   = S_FOLD;
            end
          end
        end
      end
      S_FOLD: begin
        case (muldiv_r)
          MD_TIMES: begin
            md_req.start  = 1'b1;
            md_req.is_div = 1'b0;
            state_nxt     = S_WAIT;
          end
          MD_DIV: begin
            if (lit_r == '0) begin
              term_fail    = 1'b1;
              term_fail_st = ST_SYNTAX;
            end else begin
              md_req.start  = 1'b1;
              md_req.is_div = 1'b1;
              state_nxt     = S_WAIT;
            end
          end
          default: begin
            term_ok  = 1'b1;
            term_val = {1'b0, lit_r};
          end
        endcase
      end
      S_WAIT: begin
        if (md_rsp.done) begin
          if (md_rsp.ovf) begin
            term_fail    = 1'b1;
            term_fail_st = ST_OVER;
          end else begin
            term_ok  = 1'b1;
            term_val = prod_r[DATA_W-1] ? -mag_ext : mag_ext;
          end
        end
      end
      S_SUM: begin
        state_nxt = S_IDLE;
        if (mode_r == MODE_EQ) begin
          emit = 1'b1;
          if (sum_ovf) begin
            emit_status = ST_OVER;
          end else begin
            emit_status = ST_OK;
            emit_value  = sum_ext[DATA_W-1:0];
          end
        end else if (sum_ovf) begin
          err_nxt = ST_OVER;
        end else begin
          sum_nxt    = sum_ext[DATA_W-1:0];
          prod_nxt   = '0;
          sign_nxt   = (mode_r == MODE_SUB);
          muldiv_nxt = MD_NONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished literal fold either completes the key or moves on to the sum.
    if (term_ok || term_fail) begin
      state_nxt = S_IDLE;
      if (mode_r == MODE_EQ) begin
        if (term_fail) begin
          emit        = 1'b1;
          emit_status = term_fail_st;
        end else begin
          term_nxt  = term_val;
          state_nxt = S_SUM;
        end
      end else begin
        lit_nxt        = '0;
        lit_digits_nxt = '0;
        if (term_fail) begin
          err_nxt = term_fail_st;
        end else if (mode_r == MODE_MUL || mode_r == MODE_DIV) begin
          prod_nxt   = term_val;
          muldiv_nxt = (mode_r == MODE_MUL) ? MD_TIMES : MD_DIV;
        end else begin
          term_nxt  = term_val;
          state_nxt = S_SUM;
        end
      end
    end

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_value_nxt  = (emit_status == ST_OK) ? emit_value : '0;
      set_after_eq   = 1'b1;
      if (emit_status != ST_OK) begin
        clear_req = 1'b1;
      end
    end

    if (clear_req) begin
      sum_nxt        = '0;
      prod_nxt       = '0;
      lit_nxt        = '0;
      lit_digits_nxt = '0;
      sign_nxt       = 1'b0;
      muldiv_nxt     = MD_NONE;
      key_count_nxt  = '0;
      last_op_nxt    = 1'b0;
      err_nxt        = ST_OK;
      after_eq_nxt   = 1'b0;
    end
    if (set_after_eq) begin
      after_eq_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      prod_r       <= '0;
      lit_r        <= '0;
      lit_digits_r <= '0;
      sign_r       <= 1'b0;
      muldiv_r     <= MD_NONE;
      key_count_r  <= '0;
      last_op_r    <= 1'b0;
      err_r        <= ST_OK;
      after_eq_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      prod_r       <= prod_nxt;
      lit_r        <= lit_nxt;
      lit_digits_r <= lit_digits_nxt;
      sign_r       <= sign_nxt;
      muldiv_r     <= muldiv_nxt;
      key_count_r  <= key_count_nxt;
      last_op_r    <= last_op_nxt;
      err_r        <= err_nxt;
      after_eq_r   <= after_eq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    digit_r      <= digit_nxt;
    term_r       <= term_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  `IIC_ASSERT_IMPL(a_err_value_zero, clk, rst_n, out_valid_r && (out_status_r != ST_OK), out_value_r == '0)
  `IIC_ASSERT_IMPL(a_key_count_bound, clk, rst_n, 1'b1, key_count_r <= KEY_W'(MAX_KEYS))
  `IIC_ASSERT_IMPL(a_done_in_wait, clk, rst_n, md_rsp.done, state_r == S_WAIT)
  `IIC_ASSERT_NEXT(a_start_to_wait, clk, rst_n, md_req.start, (state_r == S_WAIT) && !md_rsp.done)

endmodule

// ----- hdl/iic_muldiv.sv -----
// -----------------------------------------------------------------------------
// Iterative multiply and divide unit
// One shared adder works one bit per cycle on unsigned magnitudes: shift and
// add with saturation for multiply, restoring division for divide.
// -----------------------------------------------------------------------------
module iic_muldiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  iic_pkg::md_req_t          req,
  input  logic [iic_pkg::MAG_W-1:0] opa,
  input  logic [iic_pkg::MAG_W-1:0] opb,
  output iic_pkg::md_rsp_t          rsp,
  output logic [iic_pkg::MAG_W-1:0] res
);
  import iic_pkg::*;

  localparam int ACC_W = MAG_W + 3;
  localparam logic [ACC_W-1:0] MAG_MAX = {{(ACC_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              div_r, div_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]  a_r, a_nxt;
  logic [MAG_W-1:0]  b_r, b_nxt;
  logic [ACC_W-1:0]  opx, opy, sum;
  logic              cin;

  always_comb begin
    if (div_r) begin
      opx = {acc_r[ACC_W-2:0], a_r[MAG_W-1]};
      opy = ~{{(ACC_W-MAG_W){1'b0}}, b_r};
      cin = 1'b1;
    end else begin
      opx = {acc_r[ACC_W-2:0], 1'b0};
      opy = b_r[MAG_W-1] ? {{(ACC_W-MAG_W){1'b0}}, a_r} : '0;
      cin = 1'b0;
    end
    sum = opx + opy + {{(ACC_W-1){1'b0}}, cin};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      ovf_nxt  = 1'b0;
      cnt_nxt  = ITER_W'(MAG_W - 1);
      acc_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      if (div_r) begin
        acc_nxt = sum[ACC_W-1] ? opx : sum;
        a_nxt   = {a_r[MAG_W-2:0], ~sum[ACC_W-1]};
      end else begin
        if (sum > MAG_MAX) begin
          ovf_nxt = 1'b1;
          acc_nxt = MAG_MAX;
        end else begin
          acc_nxt = sum;
        end
        b_nxt = {b_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign res      = div_r ? a_r : acc_r[MAG_W-1:0];

endmodule

// ----- dv/infix_integer_calculator_test.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Infix integer calculator testbench
// Drives calculator keys in and checks each equals result against its table
// or a model of its own. A short table of directed keys is followed by
// random expressions, mostly well formed and partly noise, while both sides
// of the handshake idle, hold off and drain at random.
// -----------------------------------------------------------------------------
module infix_integer_calculator_test;
  import iic_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_KEYS = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
  } calc_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DIGIT_W-1:0] digit;
    logic               typed;
    calc_result_t       res;
  } key_row_t;

  logic clk;
  logic rst_n;

  iic_key_if key_ch ();
  iic_res_if res_ch ();

  infix_integer_calculator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (key_ch),
    .out_ch (res_ch)
  );

  key_row_t directed_keys [DIRECTED_ROWS] = '{
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_OK}},
    '{MODE_ADD,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_SYNTAX}},
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd15, 1'b0, '{32'sd0, ST_OK}},
    '{MODE_UNUSED, 4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd7,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIV,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_SYNTAX}},
    '{MODE_DIGIT,  4'd9,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_SUB,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_MUL,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd2,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_SYNTAX}},
    '{MODE_DIGIT,  4'd6,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_MUL,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{32'sd0, ST_SYNTAX}},
    '{MODE_DIGIT,  4'd8,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_CLR,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd3,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_SUB,    4'd0,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_DIGIT,  4'd5,  1'b0, '{32'sd0, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{-32'sd2, ST_OK}},
    '{MODE_EQ,     4'd0,  1'b1, '{-32'sd2, ST_OK}}
  };

  logic [MODE_W-1:0] arith_ops [4] = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

  longint            sum_acc;
  longint            term_acc;
  longint            literal_acc;
  bit                term_is_sub;
  logic [1:0]        muldiv_pending;
  int                keys_taken;
  bit                prev_was_op;
  logic [STAT_W-1:0] latched_status;
  bit                result_shown;

  calc_result_t pending_results [$];
  int  keys_sent;
  int  results_checked;
  int  ok_count;
  int  syntax_count;
  int  overflow_count;
  int  mismatches;
  int  stall_cycles;
  bit  quiet;
  bit  hold_req;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_calc();
    sum_acc        = 0;
    term_acc       = 0;
    literal_acc    = 0;
    term_is_sub    = 1'b0;
    muldiv_pending = MD_NONE;
    keys_taken     = 0;
    prev_was_op    = 1'b0;
    latched_status = ST_OK;
    result_shown   = 1'b0;
  endfunction

  function automatic logic [STAT_W-1:0] fold_into_term(input longint term, input logic [1:0] op,
                                                       input longint lit, output longint res);
    res = lit;
    if (op == MD_TIMES) begin
      res = term * lit;
      if (res > VALUE_MAX || res < -VALUE_MAX) return ST_OVER;
    end else if (op == MD_DIV) begin
      if (lit == 0) return ST_SYNTAX;
      res = term / lit;
    end
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] fold_into_sum(input longint sum, input bit minus,
                                                      input longint term, output longint res);
    res = minus ? sum - term : sum + term;
    if (res > VALUE_MAX || res < -VALUE_MAX) return ST_OVER;
    return ST_OK;
  endfunction

  task automatic predict_key(input logic [MODE_W-1:0] mode, input logic [DIGIT_W-1:0] digit,
                             output bit produces, output calc_result_t res);
    longint            t;
    longint            s;
    longint            nv;
    logic [STAT_W-1:0] st;
    produces   = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    t = 0;
    s = 0;
    if (mode == MODE_CLR) begin
      clear_calc();
    end else if (mode == MODE_EQ) begin
      st = latched_status;
      if (st == ST_OK && keys_taken != 0) begin
        if (prev_was_op) begin
          st = ST_SYNTAX;
        end else begin
          st = fold_into_term(term_acc, muldiv_pending, literal_acc, t);
          if (st == ST_OK) st = fold_into_sum(sum_acc, term_is_sub, t, s);
          if (st == ST_OK) res.value = s[DATA_W-1:0];
        end
      end
      if (st != ST_OK) begin
        res.value = '0;
        clear_calc();
      end
      result_shown = 1'b1;
      res.status   = st;
      produces     = 1'b1;
    end else if (mode != MODE_UNUSED && !(mode == MODE_DIGIT && digit > DIGIT_MAX)) begin
      if (result_shown) clear_calc();
      if (keys_taken < MAX_KEYS_DEF) begin
        keys_taken++;
        if (latched_status == ST_OK) begin
          if (mode == MODE_DIGIT) begin
            nv = literal_acc * 10 + longint'(digit);
            if (nv > VALUE_MAX) begin
              latched_status = ST_OVER;
            end else begin
              literal_acc = nv;
              prev_was_op = 1'b0;
            end
          end else if (keys_taken == 1 || prev_was_op) begin
            latched_status = ST_SYNTAX;
          end else begin
            prev_was_op = 1'b1;
            st = fold_into_term(term_acc, muldiv_pending, literal_acc, t);
            literal_acc = 0;
            if (st != ST_OK) begin
              latched_status = st;
            end else begin
              term_acc = t;
              if (mode == MODE_ADD || mode == MODE_SUB) begin
                st = fold_into_sum(sum_acc, term_is_sub, term_acc, s);
                if (st != ST_OK) begin
                  latched_status = st;
                end else begin
                  sum_acc        = s;
                  term_acc       = 0;
                  term_is_sub    = (mode == MODE_SUB);
                  muldiv_pending = MD_NONE;
                end
              end else begin
                muldiv_pending = (mode == MODE_MUL) ? MD_TIMES : MD_DIV;
              end
            end
          end
        end
      end
    end
  endtask

  task automatic send_key(input logic [MODE_W-1:0] mode, input logic [DIGIT_W-1:0] digit,
                          input logic typed = 1'b0, input calc_result_t typed_res = '0);
    bit           produces;
    calc_result_t predicted;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.mode  <= mode;
    key_ch.digit <= digit;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    predict_key(mode, digit, produces, predicted);
    if (produces) pending_results.push_back(typed ? typed_res : predicted);
    if (mode != MODE_UNUSED && !(mode == MODE_DIGIT && digit > DIGIT_MAX)) keys_sent++;
  endtask

  task automatic send_literal();
    int     len;
    int     pick;
    longint bound;
    longint divisor;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      bound   = VALUE_MAX + longint'($urandom_range(0, 1));
      divisor = 1000000000;
      while (divisor != 0) begin
        send_key(MODE_DIGIT, DIGIT_W'((bound / divisor) % 10));
        divisor = divisor / 10;
      end
    end else begin
      if (pick < 60) len = $urandom_range(1, 2);
      else if (pick < 85) len = $urandom_range(3, 5);
      else len = $urandom_range(9, 11);
      for (int i = 0; i < len; i++) send_key(MODE_DIGIT, DIGIT_W'($urandom_range(0, 9)));
    end
  endtask

  task automatic send_expression();
    int terms;
    int len;
    if ($urandom_range(0, 99) < 78) begin
      terms = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      for (int k = 0; k < terms; k++) begin
        if (k != 0) send_key(arith_ops[$urandom_range(0, 3)], DIGIT_W'($urandom_range(0, 15)));
        send_literal();
      end
      if ($urandom_range(0, 99) < 4) send_key(MODE_CLR, DIGIT_W'($urandom_range(0, 15)));
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_key(MODE_W'($urandom_range(0, 7)), DIGIT_W'($urandom_range(0, 15)));
      end
    end
    send_key(MODE_EQ, DIGIT_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 99) < 15) send_key(MODE_EQ, DIGIT_W'($urandom_range(0, 15)));
  endtask

  // The receiver lowers ready on its own schedule and runs the long hold-off when asked.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_req = 1'b0;
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= quiet || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    calc_result_t want;
    if (rst_n) begin
      if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Unexpected result beat: value %0d status %0d", res_ch.value, res_ch.status);
          end
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.status == ST_OK) ok_count++;
          else if (want.status == ST_SYNTAX) syntax_count++;
          else overflow_count++;
          if (res_ch.value !== want.value || res_ch.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Result mismatch: expected value %0d status %0d, got value %0d status %0d",
                       want.value, want.status, res_ch.value, res_ch.status);
            end
          end
        end
      end
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("No beat moved for %0d cycles; %0d results still outstanding.",
             WATCHDOG_LIMIT, pending_results.size());
    $display("[infix_integer_calculator] ERROR");
    $finish;
  end

  initial begin
    int expr_n;
    expr_n = 0;
    quiet  = 1'b0;
    hold_req = 1'b0;
    keys_sent = 0;
    results_checked = 0;
    ok_count = 0;
    syntax_count = 0;
    overflow_count = 0;
    mismatches = 0;
    stall_cycles = 0;
    clear_calc();
    rst_n        <= 1'b0;
    key_ch.valid <= 1'b0;
    key_ch.mode  <= MODE_CLR;
    key_ch.digit <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_key(directed_keys[r].mode, directed_keys[r].digit, directed_keys[r].typed,
               directed_keys[r].res);
    end

    while (keys_sent < DIRECTED_ROWS + RANDOM_KEYS) begin
      quiet = (expr_n >= 25 && expr_n < 40);
      if (expr_n == 10) hold_req = 1'b1;
      if (expr_n == 20 || expr_n == 50) begin
        key_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_expression();
      expr_n++;
    end
    key_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d keys in %0d random expressions; checked %0d results.",
             keys_sent, expr_n, results_checked);
    $display("Statuses seen: %0d ok, %0d syntax or divide by zero, %0d overflow; %0d mismatches.",
             ok_count, syntax_count, overflow_count, mismatches);
    if (mismatches == 0) begin
      $display("[infix_integer_calculator] OK");
    end else begin
      $display("[infix_integer_calculator] ERROR");
    end
    $finish;
  end

endmodule
